// ===== hw/rtl/motion_path_compressor_top_macros.svh =====
// assertion helpers used by the checker file
`ifndef MOTION_PATH_COMPRESSOR_TOP_MACROS_SVH
`define MOTION_PATH_COMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define MPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpc check failed");

// next-cycle implication, quiet while in reset
`define MPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpc check failed");

`endif

// ===== hw/rtl/mpc_pkg.sv =====
package mpc_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SMALL = 2'd0,
    MODE_BIG   = 2'd1,
    MODE_DIAG  = 2'd2,
    MODE_ALIAS = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_STORE,
    ST_FETCH,
    ST_DONE
  } state_e;

  // motion kinds, the left-hand variant is the right-hand one plus one
  localparam logic [4:0] K_STR      = 5'd0;
  localparam logic [4:0] K_DIAG     = 5'd1;
  localparam logic [4:0] K_SMALL_R  = 5'd2;
  localparam logic [4:0] K_SMALL_L  = 5'd3;
  localparam logic [4:0] K_90_R     = 5'd4;
  localparam logic [4:0] K_180_R    = 5'd6;
  localparam logic [4:0] K_45IN_R   = 5'd8;
  localparam logic [4:0] K_45IN_L   = 5'd9;
  localparam logic [4:0] K_45OUT_R  = 5'd10;
  localparam logic [4:0] K_135IN_R  = 5'd12;
  localparam logic [4:0] K_135IN_L  = 5'd13;
  localparam logic [4:0] K_135OUT_R = 5'd14;
  localparam logic [4:0] K_OBL90_R  = 5'd16;
  localparam logic [4:0] K_OBL90_L  = 5'd17;
  localparam logic [4:0] K_PIVOT    = 5'd18;

  localparam int unsigned WORK_SLOTS = 6;
  localparam int unsigned ENTRY_W    = 13;
  localparam int unsigned PADDR_W    = 3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] motion_kind;
    logic [7:0] motion_length;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [4:0] entry_kind;
    logic [7:0] entry_length;
    logic [8:0] entry_count;
    logic       overflow;
  } out_t;

  // working copy of the stack top, slot n-1 is the top
  typedef struct packed {
    logic [WORK_SLOTS-1:0][4:0] kind;
    logic [WORK_SLOTS-1:0][7:0] len;
    logic [2:0]                 n;
  } work_t;

endpackage

// ===== hw/rtl/motion_path_compressor_top.sv =====
// Motion path compressor: a stack of up to STACK_DEPTH motion entries that
// folds each pushed elementary motion into larger turns and straights.
// One item is taken at a time. A put fetches up to the top three entries from
// the entry memory one per cycle, rewrites them and writes back up to four
// entries one per cycle; a push that would overflow the stack is dropped.
// The next item may be taken while a result beat still waits in the output
// register. compress_mode sits at byte address 0 of the register port and may
// only be written while the block is idle.
module motion_path_compressor_top #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mpc_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mpc_pkg::out_t                out_data_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mpc_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = CW + 9;

  mpc_pkg::state_e state_q, state_d;

  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   base_q, base_d;
  logic [1:0]      mode_q;
  logic [1:0]      cmd_q, cmd_d;
  logic [4:0]      kind_q, kind_d;
  logic [7:0]      len_q, len_d;
  logic            hit_q, hit_d;
  logic            ovf_q, ovf_d;
  logic [4:0]      res_kind_q, res_kind_d;
  logic [7:0]      res_len_q, res_len_d;
  logic [2:0]      ptr_q, ptr_d;
  logic [2:0]      cap_ptr_q, cap_ptr_d;
  logic            cap_vld_q, cap_vld_d;
  mpc_pkg::work_t  work_q, work_d, work_new;
  logic            out_valid_q, out_valid_d;
  mpc_pkg::out_t   out_q, out_d;

  logic                           in_fire;
  logic                           out_free;
  logic                           issue;
  logic                           store_more;
  logic                           grow_ovf;
  logic [XW-1:0]                  idx_x;
  logic [XW-1:0]                  count_x;
  logic [CW:0]                    new_top;
  logic [2:0]                     n_load;
  logic [4:0]                     in_kind;
  logic [CW-1:0]                  rd_sum;
  logic [CW-1:0]                  wr_sum;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [mpc_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [mpc_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                           cfg_wr;

  // register port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0);
  assign prdata_o = (paddr_i[2] == 1'b0) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mpc_pkg::MODE_DIAG;
    end else if (cfg_wr) begin
      mode_q <= pwdata_i[1:0];
    end
  end

  assign in_ready_o  = (state_q == mpc_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_kind = (in_data_i.motion_kind > mpc_pkg::K_PIVOT) ? mpc_pkg::K_PIVOT
                                                               : in_data_i.motion_kind;
  assign n_load  = (count_q < CW'(3)) ? count_q[2:0] : 3'd3;

  assign idx_x   = XW'(in_data_i.read_index);
  assign count_x = XW'(count_q);

  assign issue      = ptr_q < work_q.n;
  assign store_more = ptr_q < work_q.n;
  assign rd_sum     = base_q + CW'(ptr_q);
  assign wr_sum     = base_q + CW'(ptr_q);
  assign new_top    = {1'b0, base_q} + (CW + 1)'(work_new.n);
  assign grow_ovf   = new_top > (CW + 1)'(STACK_DEPTH);

  mpc_rewrite u_rewrite (
    .work_i (work_q),
    .kind_i (kind_q),
    .len_i  (len_q),
    .mode_i (mode_q),
    .work_o (work_new)
  );

  mpc_ram #(
    .WIDTH (mpc_pkg::ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpc_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.cmd)
            mpc_pkg::CMD_PUT:  state_d = mpc_pkg::ST_LOAD;
            mpc_pkg::CMD_READ: state_d = mpc_pkg::ST_FETCH;
            default:           state_d = mpc_pkg::ST_DONE;
          endcase
        end
      end
      mpc_pkg::ST_LOAD: begin
        if (!issue) begin
          state_d = mpc_pkg::ST_CALC;
        end
      end
      mpc_pkg::ST_CALC: begin
        state_d = grow_ovf ? mpc_pkg::ST_DONE : mpc_pkg::ST_STORE;
      end
      mpc_pkg::ST_STORE: begin
        if (!store_more) begin
          state_d = mpc_pkg::ST_DONE;
        end
      end
      mpc_pkg::ST_FETCH: begin
        state_d = mpc_pkg::ST_DONE;
      end
      mpc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpc_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    base_d      = base_q;
    cmd_d       = cmd_q;
    kind_d      = kind_q;
    len_d       = len_q;
    hit_d       = hit_q;
    ovf_d       = ovf_q;
    res_kind_d  = res_kind_q;
    res_len_d   = res_len_q;
    ptr_d       = ptr_q;
    cap_ptr_d   = cap_ptr_q;
    cap_vld_d   = 1'b0;
    work_d      = work_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_sum[AW-1:0];
    ram_wdata   = {work_q.kind[ptr_q], work_q.len[ptr_q]};
    ram_raddr   = rd_sum[AW-1:0];

    // fetched entry from the previous cycle's read
    if (cap_vld_q) begin
      work_d.kind[cap_ptr_q] = ram_rdata[12:8];
      work_d.len[cap_ptr_q]  = ram_rdata[7:0];
    end

    unique case (state_q)
      mpc_pkg::ST_IDLE: begin
        ram_raddr = idx_x[AW-1:0];
        if (in_fire) begin
          cmd_d      = in_data_i.cmd;
          kind_d     = in_kind;
          len_d      = (in_kind == mpc_pkg::K_STR) ? 8'd2 : in_data_i.motion_length;
          hit_d      = idx_x < count_x;
          ovf_d      = 1'b0;
          res_kind_d = mpc_pkg::K_STR;
          res_len_d  = 8'd0;
          base_d     = count_q - CW'(n_load);
          work_d.n   = n_load;
          ptr_d      = 3'd0;
          if (in_data_i.cmd == mpc_pkg::CMD_CLEAR) begin
            count_d = '0;
          end
        end
      end
      mpc_pkg::ST_LOAD: begin
        if (issue) begin
          ptr_d     = ptr_q + 3'd1;
          cap_vld_d = 1'b1;
          cap_ptr_d = ptr_q;
        end
      end
      mpc_pkg::ST_CALC: begin
        work_d = work_new;
        ptr_d  = 3'd0;
        if (grow_ovf) begin
          ovf_d = 1'b1;
        end else begin
          count_d = new_top[CW-1:0];
        end
      end
      mpc_pkg::ST_STORE: begin
        if (store_more) begin
          ram_we = 1'b1;
          ptr_d  = ptr_q + 3'd1;
        end
      end
      mpc_pkg::ST_FETCH: begin
        res_kind_d = hit_q ? ram_rdata[12:8] : mpc_pkg::K_PIVOT;
        res_len_d  = hit_q ? ram_rdata[7:0] : 8'd1;
      end
      mpc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.entry_kind   = res_kind_q;
          out_d.entry_length = res_len_q;
          out_d.entry_count  = count_x[8:0];
          out_d.overflow     = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpc_pkg::ST_IDLE;
      count_q     <= '0;
      cap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_vld_q   <= cap_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    cmd_q      <= cmd_d;
    kind_q     <= kind_d;
    len_q      <= len_d;
    hit_q      <= hit_d;
    ovf_q      <= ovf_d;
    res_kind_q <= res_kind_d;
    res_len_q  <= res_len_d;
    ptr_q      <= ptr_d;
    cap_ptr_q  <= cap_ptr_d;
    work_q     <= work_d;
    out_q      <= out_d;
  end

endmodule

// ===== hw/rtl/mpc_ram.sv =====
module mpc_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mpc_rewrite.sv =====
module mpc_rewrite (
  input  mpc_pkg::work_t work_i,
  input  logic [4:0]     kind_i,
  input  logic [7:0]     len_i,
  input  logic [1:0]     mode_i,
  output mpc_pkg::work_t work_o
);

  function automatic logic [2:0] pos_of(mpc_pkg::work_t w, logic [1:0] k);
    return w.n - 3'd1 - {1'b0, k};
  endfunction

  function automatic logic present(mpc_pkg::work_t w, logic [1:0] k);
    return {1'b0, k} < w.n;
  endfunction

  function automatic logic [4:0] top_kind(mpc_pkg::work_t w, logic [1:0] k);
    return present(w, k) ? w.kind[pos_of(w, k)] : mpc_pkg::K_PIVOT;
  endfunction

  function automatic logic [7:0] top_len(mpc_pkg::work_t w, logic [1:0] k);
    return present(w, k) ? w.len[pos_of(w, k)] : 8'd1;
  endfunction

  function automatic mpc_pkg::work_t set_len(mpc_pkg::work_t w, logic [1:0] k,
                                             logic [7:0] v);
    mpc_pkg::work_t r;
    r = w;
    if (present(w, k)) begin
      r.len[pos_of(w, k)] = v;
    end
    return r;
  endfunction

  function automatic mpc_pkg::work_t pop_one(mpc_pkg::work_t w);
    mpc_pkg::work_t r;
    r = w;
    if (w.n != 3'd0) begin
      r.n = w.n - 3'd1;
    end
    return r;
  endfunction

  function automatic mpc_pkg::work_t push_one(mpc_pkg::work_t w, logic [4:0] k,
                                              logic [7:0] l);
    mpc_pkg::work_t r;
    r = w;
    if (w.n < 3'(mpc_pkg::WORK_SLOTS)) begin
      r.kind[w.n] = k;
      r.len[w.n]  = l;
      r.n         = w.n + 3'd1;
    end
    return r;
  endfunction

  // trim one half cell off a straight, dropping it when nothing is left
  function automatic mpc_pkg::work_t shorten_or_drop(mpc_pkg::work_t w, logic [1:0] k);
    mpc_pkg::work_t r;
    logic [2:0]     pos;
    r   = w;
    pos = pos_of(w, k);
    if (top_len(w, k) <= 8'd1) begin
      for (int i = 0; i < 5; i++) begin
        if ((3'(i) >= pos) && (3'(i + 1) < w.n)) begin
          r.kind[i] = w.kind[i+1];
          r.len[i]  = w.len[i+1];
        end
      end
      r.n = w.n - 3'd1;
    end else begin
      r = set_len(w, k, top_len(w, k) - 8'd1);
    end
    return r;
  endfunction

  function automatic logic is_small(logic [4:0] k);
    return (k == mpc_pkg::K_SMALL_R) || (k == mpc_pkg::K_SMALL_L);
  endfunction

  function automatic logic is_diag(logic [4:0] k);
    return (k == mpc_pkg::K_DIAG) || (k == mpc_pkg::K_45IN_R) ||
           (k == mpc_pkg::K_45IN_L) || (k == mpc_pkg::K_135IN_R) ||
           (k == mpc_pkg::K_135IN_L) || (k == mpc_pkg::K_OBL90_R) ||
           (k == mpc_pkg::K_OBL90_L);
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] v, logic [1:0] inc);
    logic [8:0] s;
    s = {1'b0, v} + {7'd0, inc};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  function automatic mpc_pkg::work_t put_straight(mpc_pkg::work_t w, logic small_only,
                                                  logic diag);
    mpc_pkg::work_t r;
    logic [4:0]     a;
    logic [4:0]     b;
    logic [4:0]     c;
    a = top_kind(w, 2'd0);
    b = top_kind(w, 2'd1);
    c = top_kind(w, 2'd2);
    r = w;
    if (a == mpc_pkg::K_STR) begin
      r = set_len(w, 2'd0, sat_add(top_len(w, 2'd0), 2'd2));
    end else if (small_only || !is_small(a)) begin
      r = push_one(w, mpc_pkg::K_STR, 8'd2);
    end else if (b == mpc_pkg::K_STR) begin
      r = pop_one(w);
      r = shorten_or_drop(r, 2'd0);
      r = push_one(r, mpc_pkg::K_90_R | {4'd0, a[0]}, 8'd1);
      r = push_one(r, mpc_pkg::K_STR, 8'd1);
    end else if (is_small(b)) begin
      if (c == mpc_pkg::K_STR) begin
        if (a == b) begin
          r = shorten_or_drop(w, 2'd2);
          r = pop_one(pop_one(r));
          r = push_one(r, mpc_pkg::K_180_R | {4'd0, a[0]}, 8'd1);
          r = push_one(r, mpc_pkg::K_STR, 8'd1);
        end else begin
          r = push_one(w, mpc_pkg::K_STR, 8'd2);
        end
      end else if (diag && is_diag(c) && (a == b)) begin
        r = pop_one(pop_one(w));
        r = push_one(r, mpc_pkg::K_135OUT_R | {4'd0, a[0]}, 8'd1);
        r = push_one(r, mpc_pkg::K_STR, 8'd1);
      end else begin
        r = push_one(w, mpc_pkg::K_STR, 8'd2);
      end
    end else if (diag && is_diag(b)) begin
      r = pop_one(w);
      r = push_one(r, mpc_pkg::K_45OUT_R | {4'd0, a[0]}, 8'd1);
      r = push_one(r, mpc_pkg::K_STR, 8'd1);
    end else begin
      r = push_one(w, mpc_pkg::K_STR, 8'd2);
    end
    return r;
  endfunction

  function automatic mpc_pkg::work_t put_turn(mpc_pkg::work_t w, logic [4:0] k,
                                              logic [7:0] l);
    mpc_pkg::work_t r;
    logic [4:0]     a;
    logic [4:0]     b;
    logic [4:0]     c;
    a = top_kind(w, 2'd0);
    b = top_kind(w, 2'd1);
    c = top_kind(w, 2'd2);
    r = w;
    if (!is_small(a) || (a == k)) begin
      r = push_one(w, k, l);
    end else if (b == a) begin
      if (is_diag(c)) begin
        r = pop_one(pop_one(w));
        r = push_one(r, mpc_pkg::K_OBL90_R | {4'd0, a[0]}, 8'd1);
        r = push_one(r, k, l);
      end else if (c == mpc_pkg::K_STR) begin
        r = shorten_or_drop(w, 2'd2);
        r = pop_one(pop_one(r));
        r = push_one(r, mpc_pkg::K_135IN_R | {4'd0, a[0]}, 8'd1);
        r = push_one(r, k, l);
      end else begin
        r = push_one(w, k, l);
      end
    end else if (b == mpc_pkg::K_STR) begin
      r = shorten_or_drop(w, 2'd1);
      r = pop_one(r);
      r = push_one(r, mpc_pkg::K_45IN_R | {4'd0, a[0]}, 8'd1);
      r = push_one(r, k, l);
    end else if (is_diag(b)) begin
      if (b == mpc_pkg::K_DIAG) begin
        r = set_len(w, 2'd1, sat_add(top_len(w, 2'd1), 2'd1));
        r = pop_one(r);
      end else begin
        r = pop_one(w);
        r = push_one(r, mpc_pkg::K_DIAG, 8'd1);
      end
      r = push_one(r, k, l);
    end else begin
      r = push_one(w, k, l);
    end
    return r;
  endfunction

  logic small_only;
  logic diag;

  assign small_only = (mode_i == mpc_pkg::MODE_SMALL);
  // the unused fourth mode code acts as the diagonal mode
  assign diag       = (mode_i == mpc_pkg::MODE_DIAG) || (mode_i == mpc_pkg::MODE_ALIAS);

  always_comb begin
    if (kind_i == mpc_pkg::K_STR) begin
      work_o = put_straight(work_i, small_only, diag);
    end else if (diag) begin
      work_o = put_turn(work_i, kind_i, len_i);
    end else begin
      work_o = push_one(work_i, kind_i, len_i);
    end
  end

endmodule

// ===== hw/rtl/mpc_checker.sv =====
`include "motion_path_compressor_top_macros.svh"

module mpc_checker #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mpc_pkg::out_t out_data_o
);

  // a stalled result beat holds
  `MPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // one item at a time: busy right after taking a beat
  `MPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // a dropped push never carries read data
  `MPC_ASSERT_NOW(a_ovf_no_entry, out_valid_o && out_data_o.overflow,
                  (out_data_o.entry_kind == mpc_pkg::K_STR) && (out_data_o.entry_length == 8'd0))

  // the stack never holds more than its depth
  `MPC_ASSERT_NOW(a_count_bound, out_valid_o, 32'(out_data_o.entry_count) <= STACK_DEPTH)

endmodule

bind motion_path_compressor_top mpc_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_mpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/motion_path_compressor_top_test.sv =====
module motion_path_compressor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned LIMIT     = 500000;
  localparam int unsigned PLAN_LEN  = 25;
  localparam int unsigned HOLD_AT   = 60;
  localparam int unsigned HOLD_LEN  = 400;
  localparam logic [mpc_pkg::PADDR_W-1:0] MODE_ADDR = '0;

  typedef struct packed {
    mpc_pkg::in_t  stim;
    bit            typed;
    mpc_pkg::out_t want;
  } row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  mpc_pkg::in_t                 in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  mpc_pkg::out_t                out_data_o;
  logic                         psel_i;
  logic                         penable_i;
  logic                         pwrite_i;
  logic [mpc_pkg::PADDR_W-1:0]  paddr_i;
  logic [31:0]                  pwdata_i;
  logic [31:0]                  prdata_o;
  logic                         pready_o;

  // shadow of the block's stack and mode
  logic [12:0]         path_stack [DEPTH];
  int unsigned         stack_fill;
  mpc_pkg::mode_e      mode_reg;
  logic [4:0]          top_k [mpc_pkg::WORK_SLOTS];
  logic [7:0]          top_l [mpc_pkg::WORK_SLOTS];
  int unsigned         top_n;

  mpc_pkg::out_t       due_replies [$];
  row_t                plan [PLAN_LEN];
  int unsigned         burst_left;
  int unsigned         replies_seen;
  int unsigned         fail_count;
  int unsigned         cycle_count;

  motion_path_compressor_top #(
    .STACK_DEPTH (DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [4:0] kind_at(int unsigned d);
    return (d < top_n) ? top_k[top_n - 1 - d] : mpc_pkg::K_PIVOT;
  endfunction

  function automatic int unsigned len_at(int unsigned d);
    return (d < top_n) ? int'(top_l[top_n - 1 - d]) : 1;
  endfunction

  function automatic void set_len_at(int unsigned d, int unsigned v);
    if (d < top_n) top_l[top_n - 1 - d] = v[7:0];
  endfunction

  function automatic void grow_len(int unsigned d, int unsigned step);
    int unsigned v;
    v = len_at(d) + step;
    set_len_at(d, (v > 255) ? 255 : v);
  endfunction

  function automatic void pop_top();
    if (top_n > 0) top_n--;
  endfunction

  function automatic void push_top(logic [4:0] k, logic [7:0] l);
    if (top_n < mpc_pkg::WORK_SLOTS) begin
      top_k[top_n] = k;
      top_l[top_n] = l;
      top_n++;
    end
  endfunction

  function automatic bit is_small90(logic [4:0] k);
    return k == mpc_pkg::K_SMALL_R || k == mpc_pkg::K_SMALL_L;
  endfunction

  function automatic bit is_oblique(logic [4:0] k);
    return k inside {mpc_pkg::K_DIAG, mpc_pkg::K_45IN_R, mpc_pkg::K_45IN_L,
                     mpc_pkg::K_135IN_R, mpc_pkg::K_135IN_L, mpc_pkg::K_OBL90_R,
                     mpc_pkg::K_OBL90_L};
  endfunction

  // a straight that would shrink to nothing leaves the stack
  function automatic void trim_straight(int unsigned d);
    int unsigned i;
    if (len_at(d) <= 1) begin
      for (i = top_n - 1 - d; i + 1 < top_n; i++) begin
        top_k[i] = top_k[i + 1];
        top_l[i] = top_l[i + 1];
      end
      top_n--;
    end else begin
      set_len_at(d, len_at(d) - 1);
    end
  endfunction

  function automatic void fold_straight(mpc_pkg::mode_e m);
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    a = kind_at(0);
    b = kind_at(1);
    c = kind_at(2);
    if (a == mpc_pkg::K_STR) begin
      grow_len(0, 2);
      return;
    end
    if (m == mpc_pkg::MODE_SMALL || !is_small90(a)) begin
      push_top(mpc_pkg::K_STR, 8'd2);
      return;
    end
    if (b == mpc_pkg::K_STR) begin
      pop_top();
      trim_straight(0);
      push_top(mpc_pkg::K_90_R + a[0], 8'd1);
      push_top(mpc_pkg::K_STR, 8'd1);
    end else if (is_small90(b)) begin
      if (c == mpc_pkg::K_STR) begin
        if (a == b) begin
          trim_straight(2);
          pop_top();
          pop_top();
          push_top(mpc_pkg::K_180_R + a[0], 8'd1);
          push_top(mpc_pkg::K_STR, 8'd1);
        end else begin
          push_top(mpc_pkg::K_STR, 8'd2);
        end
      end else if (m == mpc_pkg::MODE_DIAG && is_oblique(c) && a == b) begin
        pop_top();
        pop_top();
        push_top(mpc_pkg::K_135OUT_R + a[0], 8'd1);
        push_top(mpc_pkg::K_STR, 8'd1);
      end else begin
        push_top(mpc_pkg::K_STR, 8'd2);
      end
    end else if (m == mpc_pkg::MODE_DIAG && is_oblique(b)) begin
      pop_top();
      push_top(mpc_pkg::K_45OUT_R + a[0], 8'd1);
      push_top(mpc_pkg::K_STR, 8'd1);
    end else begin
      push_top(mpc_pkg::K_STR, 8'd2);
    end
  endfunction

  function automatic void fold_turn(logic [4:0] k, logic [7:0] l);
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    a = kind_at(0);
    b = kind_at(1);
    c = kind_at(2);
    if (!is_small90(a) || a == k) begin
      push_top(k, l);
      return;
    end
    if (b == a) begin
      if (is_oblique(c)) begin
        pop_top();
        pop_top();
        push_top(mpc_pkg::K_OBL90_R + a[0], 8'd1);
      end else if (c == mpc_pkg::K_STR) begin
        trim_straight(2);
        pop_top();
        pop_top();
        push_top(mpc_pkg::K_135IN_R + a[0], 8'd1);
      end
    end else if (b == mpc_pkg::K_STR) begin
      trim_straight(1);
      pop_top();
      push_top(mpc_pkg::K_45IN_R + a[0], 8'd1);
    end else if (is_oblique(b)) begin
      if (b == mpc_pkg::K_DIAG) begin
        grow_len(1, 1);
        pop_top();
      end else begin
        pop_top();
        push_top(mpc_pkg::K_DIAG, 8'd1);
      end
    end
    push_top(k, l);
  endfunction

  function automatic mpc_pkg::out_t predict_reply(mpc_pkg::in_t it);
    mpc_pkg::out_t  r;
    logic [4:0]     k;
    mpc_pkg::mode_e m;
    int unsigned    keep;
    int unsigned    base;
    int unsigned    i;
    r = '0;
    k = (it.motion_kind > mpc_pkg::K_PIVOT) ? mpc_pkg::K_PIVOT : it.motion_kind;
    case (it.cmd)
      mpc_pkg::CMD_READ: begin
        if (it.read_index < stack_fill) begin
          {r.entry_kind, r.entry_length} = path_stack[it.read_index];
        end else begin
          r.entry_kind   = mpc_pkg::K_PIVOT;
          r.entry_length = 8'd1;
        end
      end
      mpc_pkg::CMD_CLEAR: begin
        stack_fill = 0;
      end
      mpc_pkg::CMD_PUT: begin
        m    = (mode_reg == mpc_pkg::MODE_ALIAS) ? mpc_pkg::MODE_DIAG : mode_reg;
        keep = (stack_fill < 3) ? stack_fill : 3;
        base = stack_fill - keep;
        for (i = 0; i < keep; i++) {top_k[i], top_l[i]} = path_stack[base + i];
        top_n = keep;
        if (k == mpc_pkg::K_STR) fold_straight(m);
        else if (m == mpc_pkg::MODE_DIAG) fold_turn(k, it.motion_length);
        else push_top(k, it.motion_length);
        if (base + top_n > DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          for (i = 0; i < top_n; i++) path_stack[base + i] = {top_k[i], top_l[i]};
          stack_fill = base + top_n;
        end
      end
      default: ;
    endcase
    r.entry_count = stack_fill[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic mpc_pkg::in_t item_of(mpc_pkg::cmd_e c, logic [4:0] k);
    mpc_pkg::in_t d;
    d.cmd           = c;
    d.motion_kind   = k;
    d.motion_length = 8'($urandom_range(0, 255));
    d.read_index    = 8'($urandom_range(0, 255));
    return d;
  endfunction

  function automatic row_t row(mpc_pkg::cmd_e c, logic [4:0] k, logic [7:0] l,
                               logic [7:0] x, bit typed = 1'b0, logic [4:0] wk = '0,
                               logic [7:0] wl = '0, logic [8:0] wc = '0);
    row_t r;
    r.stim  = '{cmd: c, motion_kind: k, motion_length: l, read_index: x};
    r.typed = typed;
    r.want  = '{entry_kind: wk, entry_length: wl, entry_count: wc, overflow: 1'b0};
    return r;
  endfunction

  // called and left at a falling edge; the payload holds until the beat is taken
  task automatic offer(input mpc_pkg::in_t d, input bit typed = 1'b0,
                       input mpc_pkg::out_t want = '0);
    mpc_pkg::out_t guess;
    int unsigned   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = predict_reply(d);
    due_replies = {due_replies, (typed ? want : guess)};
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (due_replies.size() != 0);
  endtask

  task automatic write_mode(input mpc_pkg::mode_e m);
    logic [31:0] word;
    word = ($urandom & ~32'h3) | 32'(m);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= MODE_ADDR;
    pwdata_i  <= word;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    mode_reg = mpc_pkg::mode_e'(word[1:0]);
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // mostly maze-like runs of straights and small turns, some noise
  task automatic run_maze(input int unsigned n);
    mpc_pkg::in_t seq [$];
    mpc_pkg::in_t d;
    int unsigned  sent;
    int unsigned  seg;
    int unsigned  reps;
    int unsigned  pick;
    int unsigned  j;
    logic [4:0]   side;
    sent = 0;
    while (sent < n) begin
      seq.delete();
      seg  = $urandom_range(0, 19);
      side = $urandom_range(0, 1) ? mpc_pkg::K_SMALL_L : mpc_pkg::K_SMALL_R;
      if (seg < 6) begin
        reps = $urandom_range(1, 4);
        repeat (reps) seq = {seq, item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR)};
      end else if (seg < 10) begin
        seq = {seq, item_of(mpc_pkg::CMD_PUT, side)};
        seq = {seq, item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR)};
      end else if (seg < 13) begin
        repeat (2) seq = {seq, item_of(mpc_pkg::CMD_PUT, side)};
        seq = {seq, item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR)};
      end else if (seg < 16) begin
        reps = $urandom_range(2, 8);
        for (j = 0; j < reps; j++) seq = {seq, item_of(mpc_pkg::CMD_PUT, side ^ j[0])};
        if ($urandom_range(0, 1)) seq = {seq, item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR)};
      end else begin
        pick = $urandom_range(0, 7);
        if (pick < 3) begin
          d = item_of(mpc_pkg::CMD_READ, 5'($urandom_range(0, 31)));
          if (stack_fill > 0 && $urandom_range(0, 1))
            d.read_index = 8'($urandom_range(0, stack_fill - 1));
        end else if (pick < 6) begin
          d = item_of(mpc_pkg::CMD_PUT, 5'($urandom_range(0, 31)));
        end else if (pick == 6) begin
          d = item_of(mpc_pkg::CMD_NOP, 5'($urandom_range(0, 31)));
        end else begin
          d = item_of(mpc_pkg::CMD_CLEAR, 5'($urandom_range(0, 31)));
        end
        seq = {seq, d};
      end
      for (j = 0; j < seq.size(); j++) offer(seq[j]);
      sent += seq.size();
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel_i     = 1'b0;
    penable_i  = 1'b0;
    pwrite_i   = 1'b0;
    paddr_i    = '0;
    pwdata_i   = '0;
    stack_fill = 0;
    mode_reg   = mpc_pkg::MODE_DIAG;
    burst_left = 0;

    plan = '{
      row(mpc_pkg::CMD_READ,  mpc_pkg::K_STR,     8'd0,   8'd0,   1'b1,
          mpc_pkg::K_PIVOT, 8'd1, 9'd0),
      row(mpc_pkg::CMD_READ,  mpc_pkg::K_STR,     8'd0,   8'd255, 1'b1,
          mpc_pkg::K_PIVOT, 8'd1, 9'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_STR,     8'd255, 8'd0,   1'b1,
          mpc_pkg::K_STR,   8'd0, 9'd1),
      row(mpc_pkg::CMD_READ,  mpc_pkg::K_STR,     8'd0,   8'd0,   1'b1,
          mpc_pkg::K_STR,   8'd2, 9'd1),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_STR,     8'd0,   8'd0),       // large 90
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_L, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_L, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_STR,     8'd0,   8'd0),       // 180
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_L, 8'd1,   8'd0),       // 45 in
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),       // diagonal starts
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_STR,     8'd0,   8'd0),       // 135 out
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_L, 8'd1,   8'd0),       // 135 in
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_R, 8'd1,   8'd0),
      row(mpc_pkg::CMD_PUT,   mpc_pkg::K_SMALL_L, 8'd1,   8'd0),       // oblique 90
      row(mpc_pkg::CMD_PUT,   5'd31,              8'd0,   8'd0),       // taken as pivot
      row(mpc_pkg::CMD_NOP,   5'd31,              8'd255, 8'd255),
      row(mpc_pkg::CMD_READ,  5'd31,              8'd255, 8'd1),
      row(mpc_pkg::CMD_CLEAR, 5'd31,              8'd255, 8'd255, 1'b1,
          mpc_pkg::K_STR,   8'd0, 9'd0),
      row(mpc_pkg::CMD_READ,  mpc_pkg::K_STR,     8'd0,   8'd0,   1'b1,
          mpc_pkg::K_PIVOT, 8'd1, 9'd0)
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < PLAN_LEN; i++) offer(plan[i].stim, plan[i].typed, plan[i].want);
    run_maze(50);
    settle();
    run_maze(30);

    // straights merge and saturate, then the stack is filled past its depth
    settle();
    write_mode(mpc_pkg::MODE_SMALL);
    offer(item_of(mpc_pkg::CMD_CLEAR, mpc_pkg::K_STR));
    repeat (130) offer(item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR));
    for (i = 0; i < 262; i++) begin
      if (i % 16 == 0) offer(item_of(mpc_pkg::CMD_READ, 5'($urandom_range(0, 31))));
      offer(item_of(mpc_pkg::CMD_PUT, 5'($urandom_range(1, 31))));
    end
    repeat (2) offer(item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR));
    repeat (4) offer(item_of(mpc_pkg::CMD_READ, 5'($urandom_range(0, 31))));

    settle();
    write_mode(mpc_pkg::MODE_BIG);
    run_maze(15);
    offer(item_of(mpc_pkg::CMD_CLEAR, mpc_pkg::K_STR));
    run_maze(45);

    settle();
    write_mode(mpc_pkg::MODE_ALIAS);
    run_maze(60);

    // long zigzag drives the diagonal straight into saturation
    settle();
    write_mode(mpc_pkg::MODE_DIAG);
    offer(item_of(mpc_pkg::CMD_CLEAR, mpc_pkg::K_STR));
    offer(item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_STR));
    for (i = 0; i < 262; i++) offer(item_of(mpc_pkg::CMD_PUT, mpc_pkg::K_SMALL_R ^ 5'(i[0])));
    run_maze(20);

    settle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int unsigned span;
    int unsigned style;
    logic [7:0]  pat;
    bit          held;
    out_ready_i = 1'b0;
    held = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 80);
      pat   = 8'($urandom);
      repeat (span) begin
        @(negedge clk_i);
        // one long hold so the block backs up onto its input
        if (!held && replies_seen >= HOLD_AT) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_LEN) @(negedge clk_i);
        end
        case (style)
          0: out_ready_i <= 1'b1;
          1: begin
            out_ready_i <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          2: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : reply_check
    mpc_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      replies_seen++;
      if (due_replies.size() == 0) begin
        fail_count++;
        $display("%0t ns: reply beat with none expected, expected none, got %h",
                 $time, out_data_o);
      end else begin
        want = due_replies.pop_front();
        compare_field("entry_kind", want.entry_kind, out_data_o.entry_kind);
        compare_field("entry_length", want.entry_length, out_data_o.entry_length);
        compare_field("entry_count", want.entry_count, out_data_o.entry_count);
        compare_field("overflow", want.overflow, out_data_o.overflow);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
